@@ src/nfl_pkg.sv @@
// Shared types, codes and constants for the newest-files sorted list.
package nfl_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int OUT_CNT_W    = 9;
  localparam int RD_IDX_W     = 8;
  localparam int YEAR_BASE    = 80;
  localparam int YEAR_CEIL    = 100;
  localparam int YEAR_SHIFT   = 9;
  localparam int YEAR_W       = 16 - YEAR_SHIFT;
  localparam logic [YEAR_W-1:0] YEAR_LIMIT = YEAR_W'(YEAR_CEIL - YEAR_BASE);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic [15:0] fdate;
    logic [15:0] ftime;
    logic [31:0] fsize;
    logic [31:0] ftag;
  } entry_t;

  typedef struct packed {
    logic   ins_en;
    entry_t item;
  } ins_req_t;

endpackage

@@ src/nfl_cell.sv @@
// One list position: holds an entry, compares against the broadcast record, shifts down.
module nfl_cell #(
  parameter int CAPACITY = nfl_pkg::CAPACITY_DEF,
  parameter int IDX      = 0
) (
  input  logic                              clk,
  input  nfl_pkg::ins_req_t                 ins_req,
  input  logic [$clog2(CAPACITY+1)-1:0]     count,
  input  logic [nfl_pkg::RD_IDX_W-1:0]      rd_idx,
  input  logic                              prev_hit,
  input  nfl_pkg::entry_t                   prev_entry,
  output logic                              hit,
  output logic                              first,
  output nfl_pkg::entry_t                   entry,
  output nfl_pkg::entry_t                   rd_data
);
  import nfl_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] IDXC = CW'(IDX);
  localparam bit RD_OK = (IDX < (1 << RD_IDX_W));
  localparam logic [RD_IDX_W-1:0] IDX8 = RD_IDX_W'(IDX % (1 << RD_IDX_W));

  entry_t entry_r;
  logic   in_list;
  logic   newer;
  logic   rd_sel;

  always_comb begin
    in_list = (IDXC < count);
    newer   = (ins_req.item.fdate > entry_r.fdate) ||
              ((ins_req.item.fdate == entry_r.fdate) &&
               (ins_req.item.ftime > entry_r.ftime));
    hit     = !in_list || newer;
    first   = hit && !prev_hit;
    rd_sel  = RD_OK && (rd_idx == IDX8);
    rd_data = rd_sel ? entry_r : '0;
    entry   = entry_r;
  end

  always_ff @(posedge clk) begin
    if (ins_req.ins_en) begin
      if (first) begin
        entry_r <= ins_req.item;
      end else if (prev_hit) begin
        entry_r <= prev_entry;
      end
    end
  end

endmodule

@@ src/nfl_gather.sv @@
// Collects the insert position and the read entry from the cell row.
module nfl_gather #(
  parameter int CAPACITY = nfl_pkg::CAPACITY_DEF
) (
  input  logic [CAPACITY-1:0]           first,
  input  nfl_pkg::entry_t               rd_data [CAPACITY],
  output logic [$clog2(CAPACITY)-1:0]   pos,
  output nfl_pkg::entry_t               rd_entry
);
  import nfl_pkg::*;

  localparam int PW = $clog2(CAPACITY);

  always_comb begin
    pos      = '0;
    rd_entry = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first[i]) begin
        pos = pos | PW'(i);
      end
      rd_entry = rd_entry | rd_data[i];
    end
  end

endmodule

@@ src/newest_files_topk_list.sv @@
// A transaction is registered at accept, executed in ST_EXEC, its result registered;
// execution waits while a result is held and out_ready is low. New transactions are
// taken only in ST_IDLE; the whole cell row compares and shifts together on go.
// A new transaction is taken while the previous result waits in the output register.
// Reset (rst_n low, synchronous) empties the list and clears out_valid;
// stored entries stay undefined until written, with no clearing pass.
module newest_files_topk_list #(
  parameter int CAPACITY = nfl_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_command,
  input  logic [15:0]                     in_file_date,
  input  logic [15:0]                     in_file_time,
  input  logic [31:0]                     in_file_size,
  input  logic [31:0]                     in_file_tag,
  input  logic [nfl_pkg::RD_IDX_W-1:0]    in_read_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_accepted,
  output logic [nfl_pkg::OUT_CNT_W-1:0]   out_insert_position,
  output logic [nfl_pkg::OUT_CNT_W-1:0]   out_list_count,
  output logic                            out_read_valid,
  output logic [15:0]                     out_date,
  output logic [15:0]                     out_time,
  output logic [31:0]                     out_size,
  output logic [31:0]                     out_tag
);
  import nfl_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = $clog2(CAPACITY);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  state_t                 state_r, state_nxt;
  cmd_t                   cmd_r;
  entry_t                 item_r;
  logic [RD_IDX_W-1:0]    idx_r;
  logic [CW-1:0]          count_r, count_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_accepted_r;
  logic [OUT_CNT_W-1:0]   out_pos_r;
  logic [OUT_CNT_W-1:0]   out_count_r;
  logic                   out_read_valid_r;
  entry_t                 out_entry_r;

  logic                   in_go;
  logic                   go;
  logic                   year_ok;
  logic                   acc;
  logic                   rv;
  ins_req_t               ins_req;

  logic [CAPACITY-1:0]    hit;
  logic [CAPACITY-1:0]    first;
  entry_t                 entries [CAPACITY];
  entry_t                 rd_data [CAPACITY];
  logic [PW-1:0]          pos_enc;
  entry_t                 rd_entry;

  always_comb begin
    in_ready = (state_r == ST_IDLE);
    go       = (state_r == ST_EXEC) && (!out_valid_r || out_ready);
    in_go    = in_valid && in_ready;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_go) state_nxt = ST_EXEC;
      ST_EXEC: if (go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    year_ok        = (item_r.fdate[15:YEAR_SHIFT] < YEAR_LIMIT);
    acc            = (cmd_r == CMD_INSERT) && year_ok && hit[CAPACITY-1];
    rv             = (cmd_r == CMD_READ) && (32'(idx_r) < 32'(count_r)) &&
                     (32'(idx_r) < CAPACITY);
    ins_req.ins_en = go && acc;
    ins_req.item   = item_r;
    count_nxt      = count_r;
    if (go) begin
      if (acc && (count_r < CAP_C)) begin
        count_nxt = count_r + CW'(1);
      end else if (cmd_r == CMD_CLEAR) begin
        count_nxt = '0;
      end
    end
    out_valid_nxt = out_valid_r;
    if (go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_head
        nfl_cell #(.CAPACITY(CAPACITY), .IDX(g)) u_cell (
          .clk        (clk),
          .ins_req    (ins_req),
          .count      (count_r),
          .rd_idx     (idx_r),
          .prev_hit   (1'b0),
          .prev_entry ('0),
          .hit        (hit[g]),
          .first      (first[g]),
          .entry      (entries[g]),
          .rd_data    (rd_data[g])
        );
      end else begin : g_body
        nfl_cell #(.CAPACITY(CAPACITY), .IDX(g)) u_cell (
          .clk        (clk),
          .ins_req    (ins_req),
          .count      (count_r),
          .rd_idx     (idx_r),
          .prev_hit   (hit[g-1]),
          .prev_entry (entries[g-1]),
          .hit        (hit[g]),
          .first      (first[g]),
          .entry      (entries[g]),
          .rd_data    (rd_data[g])
        );
      end
    end
  endgenerate

  nfl_gather #(.CAPACITY(CAPACITY)) u_gather (
    .first    (first),
    .rd_data  (rd_data),
    .pos      (pos_enc),
    .rd_entry (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      cmd_r        <= cmd_t'(in_command);
      item_r.fdate <= in_file_date;
      item_r.ftime <= in_file_time;
      item_r.fsize <= in_file_size;
      item_r.ftag  <= in_file_tag;
      idx_r        <= in_read_index;
    end
    if (go) begin
      out_accepted_r   <= acc;
      out_pos_r        <= acc ? OUT_CNT_W'(pos_enc) : OUT_CNT_W'(count_nxt);
      out_count_r      <= OUT_CNT_W'(count_nxt);
      out_read_valid_r <= rv;
      out_entry_r      <= rv ? rd_entry : '0;
    end
  end

  always_comb begin
    out_valid           = out_valid_r;
    out_accepted        = out_accepted_r;
    out_insert_position = out_pos_r;
    out_list_count      = out_count_r;
    out_read_valid      = out_read_valid_r;
    out_date            = out_entry_r.fdate;
    out_time            = out_entry_r.ftime;
    out_size            = out_entry_r.fsize;
    out_tag             = out_entry_r.ftag;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("list count beyond capacity");

  a_first_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |-> $onehot0(first))
    else $error("more than one insert point in cell row");

  a_accept_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (go && acc) |=> (out_valid && out_accepted && !out_read_valid))
    else $error("insert result malformed");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !go |=> $stable(count_r))
    else $error("list count changed outside execute");

endmodule
